// File: sv/gapr_pkg.sv
package gapr_pkg;

  // Bank geometry: one bank is 16 KiB, so a CPU address splits into slot and offset
  localparam int unsigned BANK_BYTES  = 16384;
  localparam int unsigned WITHIN_W    = $clog2(BANK_BYTES);
  localparam int unsigned BANK_NUM_W  = 3;
  localparam int unsigned PHYS_W      = BANK_NUM_W + WITHIN_W;

  // Item kinds on the input channel
  localparam logic [1:0] FUNC_GA_WRITE = 2'd0;
  localparam logic [1:0] FUNC_XLATE    = 2'd1;
  localparam logic [1:0] FUNC_ROM_SEL  = 2'd2;

  // Gate array command codes, top two bits of the command byte
  localparam logic [1:0] GA_PEN_PTR = 2'b00;
  localparam logic [1:0] GA_PEN_SET = 2'b01;
  localparam logic [1:0] GA_MODE    = 2'b10;
  localparam logic [1:0] GA_BANK    = 2'b11;

  // Result target codes
  localparam logic [1:0] TGT_RAM    = 2'd0;
  localparam logic [1:0] TGT_LOWROM = 2'd1;
  localparam logic [1:0] TGT_UPROM  = 2'd2;
  localparam logic [1:0] TGT_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_EXTRA_RAM = 1'b0;
  localparam logic CFG_ROM_MASK  = 1'b1;

  localparam logic [4:0] BORDER_PEN = 5'd16;

  // Decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PEN_PTR,
    OP_PEN_SET,
    OP_MODE,
    OP_BANK,
    OP_XLATE,
    OP_ROM_SEL
  } gapr_op_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data;
    logic [15:0] cpu_address;
    logic        is_write;
    logic [3:0]  rom_number;
  } gapr_in_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [16:0] mem_offset;
    logic [3:0]  rom_index;
    logic        pen_written;
    logic [4:0]  pen_index;
    logic [5:0]  pen_colour;
    logic [1:0]  screen_mode;
    logic        palette_changed;
    logic        irq_ack;
  } gapr_out_t;

  typedef struct packed {
    gapr_op_e    op;
    logic [7:0]  data;
    logic [1:0]  slot;
    logic [WITHIN_W-1:0] bank_ofs;
    logic        is_write;
    logic [3:0]  rom_number;
  } gapr_cmd_t;

  // Bank number for a given map and CPU slot
  function automatic logic [BANK_NUM_W-1:0] bank_lookup(input logic [2:0] map,
                                                        input logic [1:0] slot);
    logic [BANK_NUM_W-1:0] bank;
    bank = 3'd0;
    unique case (map)
      3'd0: bank = {1'b0, slot};
      3'd1: bank = (slot == 2'd3) ? 3'd7 : {1'b0, slot};
      3'd2: bank = {1'b1, slot};
      3'd3: begin
        case (slot)
          2'd1:    bank = 3'd3;
          2'd3:    bank = 3'd7;
          default: bank = {1'b0, slot};
        endcase
      end
      default: bank = (slot == 2'd1) ? map : {1'b0, slot};
    endcase
    return bank;
  endfunction

endpackage

// File: sv/gapr_front.sv
module gapr_front (
  input  logic              in_valid_i,
  input  gapr_pkg::gapr_in_t in_word_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output gapr_pkg::gapr_cmd_t cmd_o
);
  import gapr_pkg::*;

  // Hold off the source while the queue has no room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the incoming word
  always_comb begin
    cmd_o.op         = OP_NONE;
    cmd_o.data       = in_word_i.data;
    cmd_o.slot       = in_word_i.cpu_address[15:WITHIN_W];
    cmd_o.bank_ofs   = in_word_i.cpu_address[WITHIN_W-1:0];
    cmd_o.is_write   = in_word_i.is_write;
    cmd_o.rom_number = in_word_i.rom_number;
    unique case (in_word_i.func)
      FUNC_GA_WRITE: begin
        unique case (in_word_i.data[7:6])
          GA_PEN_PTR: cmd_o.op = OP_PEN_PTR;
          GA_PEN_SET: cmd_o.op = OP_PEN_SET;
          GA_MODE:    cmd_o.op = OP_MODE;
          default:    cmd_o.op = OP_BANK;
        endcase
      end
      FUNC_XLATE:   cmd_o.op = OP_XLATE;
      FUNC_ROM_SEL: cmd_o.op = OP_ROM_SEL;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// File: sv/gapr_queue.sv
module gapr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gapr_pkg::gapr_cmd_t push_cmd_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output gapr_pkg::gapr_cmd_t pop_cmd_o
);
  import gapr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  gapr_cmd_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o    = (count_q == FULL);
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: sv/gapr_back.sv
module gapr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                q_valid_i,
  input  gapr_pkg::gapr_cmd_t cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  output gapr_pkg::gapr_out_t out_word_o,
  input  logic                out_stall_i
);
  import gapr_pkg::*;

  logic        extra_ram_q;
  logic [15:0] rom_mask_q;
  logic [4:0]  pen_ptr_q, pen_ptr_d;
  logic [1:0]  mode_q, mode_d;
  logic        lower_on_q, lower_on_d;
  logic        upper_on_q, upper_on_d;
  logic [2:0]  bank_map_q, bank_map_d;
  logic [3:0]  rom_sel_q, rom_sel_d;
  logic        out_valid_q;
  gapr_out_t   out_word_q;
  gapr_out_t   res;

  // Take the next word whenever the output register is free or draining
  assign pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Carry out the command against the current state
  always_comb begin
    pen_ptr_d  = pen_ptr_q;
    mode_d     = mode_q;
    lower_on_d = lower_on_q;
    upper_on_d = upper_on_q;
    bank_map_d = bank_map_q;
    rom_sel_d  = rom_sel_q;
    res        = '0;
    res.target = TGT_NONE;
    unique case (cmd_i.op)
      OP_PEN_PTR: pen_ptr_d = cmd_i.data[4:0];
      OP_PEN_SET: begin
        res.pen_colour      = {1'b0, cmd_i.data[4:0]} + 6'd1;
        res.pen_index       = pen_ptr_q[4] ? BORDER_PEN : {1'b0, pen_ptr_q[3:0]};
        res.pen_written     = 1'b1;
        res.palette_changed = 1'b1;
      end
      OP_MODE: begin
        lower_on_d          = !cmd_i.data[2];
        upper_on_d          = !cmd_i.data[3];
        mode_d              = cmd_i.data[1:0];
        res.palette_changed = (cmd_i.data[1:0] != mode_q);
        res.irq_ack         = cmd_i.data[4];
      end
      OP_BANK: bank_map_d = extra_ram_q ? cmd_i.data[2:0] : 3'd0;
      OP_XLATE: begin
        // Reads of the ROM windows go to ROM while enabled; all else to RAM
        if (!cmd_i.is_write && cmd_i.slot == 2'd0 && lower_on_q) begin
          res.target     = TGT_LOWROM;
          res.mem_offset = PHYS_W'(cmd_i.bank_ofs);
        end else if (!cmd_i.is_write && cmd_i.slot == 2'd3 && upper_on_q) begin
          res.target     = TGT_UPROM;
          res.mem_offset = PHYS_W'(cmd_i.bank_ofs);
        end else begin
          res.target     = TGT_RAM;
          res.mem_offset = {bank_lookup(bank_map_q, cmd_i.slot), cmd_i.bank_ofs};
        end
      end
      OP_ROM_SEL: rom_sel_d = cmd_i.rom_number;
      default: ;
    endcase
    res.screen_mode = mode_d;
    // Fall back to ROM 0 when the selected upper ROM is absent
    res.rom_index   = rom_mask_q[rom_sel_d] ? rom_sel_d : 4'd0;
  end

  // Hold state, configuration and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_ram_q <= 1'b1;
      rom_mask_q  <= 16'h0001;
      pen_ptr_q   <= '0;
      mode_q      <= '0;
      lower_on_q  <= 1'b1;
      upper_on_q  <= 1'b1;
      bank_map_q  <= '0;
      rom_sel_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_EXTRA_RAM: extra_ram_q <= cfg_wdata_i[0];
          default:       rom_mask_q  <= cfg_wdata_i;
        endcase
      end
      if (pop_o) begin
        pen_ptr_q  <= pen_ptr_d;
        mode_q     <= mode_d;
        lower_on_q <= lower_on_d;
        upper_on_q <= upper_on_d;
        bank_map_q <= bank_map_d;
        rom_sel_q  <= rom_sel_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_word_q <= res;
    end
  end

endmodule

// File: sv/gate_array_palette_and_ram_banking.sv
// Palette and RAM banking gate array.
// Input channel (in_valid_i / in_stall_o / in_word_i) takes one word a cycle while in_stall_o is low:
// a gate array command byte, a CPU address to translate, or an upper ROM
// select. Each word gives exactly one result word on the output channel
// (out_valid_o / out_stall_i / out_word_o), in order.
// A front stage decodes the word into a small command queue; the back stage
// executes it against the palette, mode, ROM enable and bank map state and
// loads a registered result.
// Without stalls, a word goes through the queue and then the result register.
// The back stage takes one word per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds, the queue fills and
// in_stall_o rises once QUEUE_DEPTH words wait; no word is lost.
// Reset empties the queue and output, restores mode 0, bank map 0, pen
// pointer 0, both ROMs enabled, upper ROM 0, extra RAM present and only
// upper ROM 0 present. Configuration writes (cfg_we_i) take effect at once
// and must be made while the block is idle; the block does not enforce it.
module gate_array_palette_and_ram_banking #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  gapr_pkg::gapr_in_t  in_word_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output gapr_pkg::gapr_out_t out_word_o,
  input  logic                out_stall_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_wdata_i
);
  import gapr_pkg::*;

  logic      push;
  logic      q_full;
  logic      q_valid;
  logic      pop;
  gapr_cmd_t push_cmd;
  gapr_cmd_t pop_cmd;

  gapr_front u_front (
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  gapr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd)
  );

  gapr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule
